FILE: rtl/spb_pkg.sv
package spb_pkg;

  // Angles in units of 2^-12 rad
  localparam int PI_Q     = 12868;
  localparam int TWO_PI_Q = 25736;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Item kinds
  localparam logic [1:0] KIND_SCAN  = 2'd0;
  localparam logic [1:0] KIND_ODO   = 2'd1;
  localparam logic [1:0] KIND_DRIVE = 2'd2;

  // Result kinds
  localparam logic RK_DRIVE = 1'b0;
  localparam logic RK_LED   = 1'b1;

  // Register indexes
  localparam logic [2:0] REG_ANGLE_START = 3'd0;
  localparam logic [2:0] REG_ANGLE_STEP  = 3'd1;
  localparam logic [2:0] REG_FRONT_HALF  = 3'd2;
  localparam logic [2:0] REG_BACK_HALF   = 3'd3;
  localparam logic [2:0] REG_FRONT_MARG  = 3'd4;
  localparam logic [2:0] REG_BACK_MARG   = 3'd5;

  typedef struct packed {
    logic signed [15:0] angle_start;
    logic signed [15:0] angle_step;
    logic [13:0]        front_half_width;
    logic [13:0]        back_half_width;
    logic [15:0]        front_margin;
    logic [15:0]        back_margin;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        range_mm;
    logic               last_sample;
    logic signed [15:0] speed;
    logic signed [15:0] steering;
  } item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [15:0] out_speed;
    logic signed [15:0] out_steering;
    logic               braked;
    logic               front_led;
    logic               back_led;
  } res_t;

endpackage

FILE: rtl/spb_cfg.sv
module spb_cfg
  import spb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] idx;
  logic       wr_en;

  assign idx   = paddr[4:2];
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_ANGLE_START: cfg_nxt.angle_start      = pwdata[15:0];
        REG_ANGLE_STEP:  cfg_nxt.angle_step       = pwdata[15:0];
        REG_FRONT_HALF:  cfg_nxt.front_half_width = pwdata[13:0];
        REG_BACK_HALF:   cfg_nxt.back_half_width  = pwdata[13:0];
        REG_FRONT_MARG:  cfg_nxt.front_margin     = pwdata[15:0];
        REG_BACK_MARG:   cfg_nxt.back_margin      = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ANGLE_START: prdata = {16'b0, cfg_r.angle_start};
      REG_ANGLE_STEP:  prdata = {16'b0, cfg_r.angle_step};
      REG_FRONT_HALF:  prdata = {18'b0, cfg_r.front_half_width};
      REG_BACK_HALF:   prdata = {18'b0, cfg_r.back_half_width};
      REG_FRONT_MARG:  prdata = {16'b0, cfg_r.front_margin};
      REG_BACK_MARG:   prdata = {16'b0, cfg_r.back_margin};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{16'sd0, 16'sd26, 14'd0, 14'd0, 16'd0, 16'd0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/spb_core.sv
module spb_core
  import spb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  go,
  input  item_t item,
  input  cfg_t  cfg,
  output logic  res_vld,
  output res_t  res
);

  logic               moving_r, moving_nxt;
  logic [31:0]        angle_r, angle_nxt;
  logic               scan_begin_r, scan_begin_nxt;
  logic               front_hit_r, front_hit_nxt;
  logic               back_hit_r, back_hit_nxt;
  logic               danger_ahead_r, danger_ahead_nxt;
  logic               danger_behind_r, danger_behind_nxt;

  logic signed [31:0] ang;
  logic signed [31:0] fh;
  logic signed [31:0] bh;
  logic signed [31:0] front_hi;
  logic signed [31:0] back_lo;
  logic signed [31:0] back_hi;
  logic               in_front;
  logic               in_back;
  logic               hit_f;
  logic               hit_b;
  logic               blocked;

  assign ang      = scan_begin_r ? 32'(cfg.angle_start) : $signed(angle_r);
  assign fh       = $signed({18'b0, cfg.front_half_width});
  assign bh       = $signed({18'b0, cfg.back_half_width});
  assign front_hi = 32'(TWO_PI_Q) - fh;
  assign back_lo  = 32'(PI_Q) - bh;
  assign back_hi  = 32'(PI_Q) + bh;
  assign in_front = (ang < fh) || (ang > front_hi);
  assign in_back  = (ang >= back_lo) && (ang <= back_hi);
  assign hit_f    = in_front && (item.range_mm <= cfg.front_margin);
  assign hit_b    = in_back && (item.range_mm <= cfg.back_margin);
  assign blocked  = (danger_ahead_r && (item.speed > 16'sd0)) ||
                    (danger_behind_r && (item.speed < 16'sd0));

  always_comb begin
    moving_nxt        = moving_r;
    angle_nxt         = angle_r;
    scan_begin_nxt    = scan_begin_r;
    front_hit_nxt     = front_hit_r;
    back_hit_nxt      = back_hit_r;
    danger_ahead_nxt  = danger_ahead_r;
    danger_behind_nxt = danger_behind_r;
    res_vld           = 1'b0;
    res               = '0;
    if (go) begin
      case (item.kind)
        KIND_SCAN: begin
          angle_nxt = ang + 32'(cfg.angle_step);
          if (item.last_sample) begin
            // latch the scan's hits, gated by motion, and restart
            danger_ahead_nxt  = (front_hit_r || hit_f) && moving_r;
            danger_behind_nxt = (back_hit_r || hit_b) && moving_r;
            front_hit_nxt     = 1'b0;
            back_hit_nxt      = 1'b0;
            scan_begin_nxt    = 1'b1;
            res_vld           = 1'b1;
            res.result_kind   = RK_LED;
            res.front_led     = danger_ahead_nxt;
            res.back_led      = danger_behind_nxt;
          end else begin
            front_hit_nxt  = front_hit_r || hit_f;
            back_hit_nxt   = back_hit_r || hit_b;
            scan_begin_nxt = 1'b0;
          end
        end
        KIND_ODO: begin
          moving_nxt = (item.speed != 16'sd0);
        end
        KIND_DRIVE: begin
          res_vld          = 1'b1;
          res.result_kind  = RK_DRIVE;
          res.out_speed    = blocked ? 16'sd0 : item.speed;
          res.out_steering = item.steering;
          res.braked       = blocked;
          res.front_led    = danger_ahead_r;
          res.back_led     = danger_behind_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moving_r        <= 1'b0;
      angle_r         <= '0;
      scan_begin_r    <= 1'b1;
      front_hit_r     <= 1'b0;
      back_hit_r      <= 1'b0;
      danger_ahead_r  <= 1'b0;
      danger_behind_r <= 1'b0;
    end else begin
      moving_r        <= moving_nxt;
      angle_r         <= angle_nxt;
      scan_begin_r    <= scan_begin_nxt;
      front_hit_r     <= front_hit_nxt;
      back_hit_r      <= back_hit_nxt;
      danger_ahead_r  <= danger_ahead_nxt;
      danger_behind_r <= danger_behind_nxt;
    end
  end

endmodule

FILE: rtl/scan_sector_proximity_brake.sv
// Channel  Direction  Handshake         Word
// in_      input      in_valid/in_stall   kind, range, last, speed, steering
// out_     output     out_valid/out_stall drive command or indicator update
// cfg      APB        psel/penable        six setup registers, pready tied high
//
// One word per cycle sustained while out_stall is low: input register, one
// pass of add and compare logic that also updates the scan state, then the
// result register; a word that yields a result passes both before out_valid.
// Synchronous active-low reset; the scan state starts at a scan begin.
// out_stall holds the result register; the input register keeps accepting
// as long as the result register is free or being taken this cycle.
module scan_sector_proximity_brake
  import spb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [15:0]        in_range_mm,
  input  logic               in_last_sample,
  input  logic signed [15:0] in_speed,
  input  logic signed [15:0] in_steering,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_result_kind,
  output logic signed [15:0] out_speed,
  output logic signed [15:0] out_steering,
  output logic               out_braked,
  output logic               out_front_led,
  output logic               out_back_led,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  cfg_t  cfg;
  item_t item_r;
  logic  in_vld_r;
  logic  out_vld_r;
  res_t  res_r;
  logic  adv;
  logic  go;
  logic  res_vld;
  res_t  res;

  assign pready = 1'b1;

  spb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // advance when the result register is empty or drains this cycle
  assign adv      = !out_vld_r || !out_stall;
  assign go       = in_vld_r && adv;
  assign in_stall = in_vld_r && !adv;

  spb_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .item    (item_r),
    .cfg     (cfg),
    .res_vld (res_vld),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= go && res_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= {in_kind, in_range_mm, in_last_sample, in_speed, in_steering};
    end
    if (go && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_result_kind = res_r.result_kind;
  assign out_speed       = res_r.out_speed;
  assign out_steering    = res_r.out_steering;
  assign out_braked      = res_r.braked;
  assign out_front_led   = res_r.front_led;
  assign out_back_led    = res_r.back_led;

  a_brake_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_braked |-> out_speed == 16'sd0 && out_result_kind == RK_DRIVE)
    else $error("braked word carries nonzero speed");

  a_led_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RK_LED |-> !out_braked && out_speed == 16'sd0
      && out_steering == 16'sd0)
    else $error("indicator word carries drive fields");

  a_brake_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_braked |-> out_front_led || out_back_led)
    else $error("brake without a danger flag");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld_r)
    else $error("input stalled with room downstream");

endmodule

FILE: bench/scan_sector_proximity_brake_test.sv
`timescale 1ns / 1ps

module scan_sector_proximity_brake_test;
  import spb_pkg::*;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam int          PHASE_WORDS   = 140;
  localparam int          SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 500000;

  typedef struct packed {
    item_t w;
    logic  typed;
    res_t  want;
  } dir_row_t;

  localparam res_t NO_RESULT = '0;

  // Samples land at angles 0, pi/2, pi, 3pi/2, 2pi with the directed setup.
  // Last three bits of a typed result: braked, front led, back led.
  localparam dir_row_t DIR_TAB [24] = '{
    {KIND_DRIVE,  16'd0,     1'b0, 16'h7FFF, 16'h8000, 1'b1, RK_DRIVE, 16'h7FFF, 16'h8000, 3'b000},
    {KIND_DRIVE,  16'hFFFF,  1'b1, 16'h8000, 16'h7FFF, 1'b1, RK_DRIVE, 16'h8000, 16'h7FFF, 3'b000},
    {KIND_SCAN,   16'd0,     1'b1, 16'h1234, 16'hFFFF, 1'b1, RK_LED,   16'd0,    16'd0,    3'b000},
    {KIND_ODO,    16'hFFFF,  1'b1, 16'd1,    16'hFFFF, 1'b0, NO_RESULT},
    {KIND_SCAN,   16'd500,   1'b0, 16'h8000, 16'h7FFF, 1'b0, NO_RESULT},
    {KIND_SCAN,   16'hFFFF,  1'b0, 16'd0,    16'd0,    1'b0, NO_RESULT},
    {KIND_SCAN,   16'd0,     1'b0, 16'd0,    16'd0,    1'b0, NO_RESULT},
    {KIND_SCAN,   16'd501,   1'b0, 16'd0,    16'd0,    1'b0, NO_RESULT},
    {KIND_SCAN,   16'd501,   1'b1, 16'd0,    16'd0,    1'b1, RK_LED,   16'd0,    16'd0,    3'b011},
    {KIND_DRIVE,  16'd0,     1'b0, 16'd1,    16'd100,  1'b1, RK_DRIVE, 16'd0,    16'd100,  3'b111},
    {KIND_DRIVE,  16'd0,     1'b0, 16'hFFFF, 16'hFF9C, 1'b1, RK_DRIVE, 16'd0,    16'hFF9C, 3'b111},
    {KIND_DRIVE,  16'd0,     1'b0, 16'd0,    16'd0,    1'b1, RK_DRIVE, 16'd0,    16'd0,    3'b011},
    {KIND_UNUSED, 16'hFFFF,  1'b1, 16'hFFFF, 16'hFFFF, 1'b0, NO_RESULT},
    {KIND_SCAN,   16'd501,   1'b0, 16'd0,    16'd0,    1'b0, NO_RESULT},
    {KIND_SCAN,   16'd0,     1'b0, 16'd0,    16'd0,    1'b0, NO_RESULT},
    {KIND_SCAN,   16'd501,   1'b0, 16'd0,    16'd0,    1'b0, NO_RESULT},
    {KIND_SCAN,   16'hFFFF,  1'b0, 16'd0,    16'd0,    1'b0, NO_RESULT},
    {KIND_SCAN,   16'd0,     1'b1, 16'd0,    16'd0,    1'b1, RK_LED,   16'd0,    16'd0,    3'b010},
    {KIND_DRIVE,  16'd0,     1'b0, 16'h8000, 16'd12,   1'b1, RK_DRIVE, 16'h8000, 16'd12,   3'b010},
    {KIND_DRIVE,  16'd0,     1'b0, 16'h7FFF, 16'd13,   1'b1, RK_DRIVE, 16'd0,    16'd13,   3'b110},
    {KIND_ODO,    16'd0,     1'b0, 16'd0,    16'd0,    1'b0, NO_RESULT},
    {KIND_SCAN,   16'd0,     1'b1, 16'd0,    16'd0,    1'b1, RK_LED,   16'd0,    16'd0,    3'b000},
    {KIND_DRIVE,  16'd0,     1'b0, 16'h7FFF, 16'hFFFF, 1'b1, RK_DRIVE, 16'h7FFF, 16'hFFFF, 3'b000},
    {KIND_ODO,    16'd0,     1'b0, 16'h8000, 16'd0,    1'b0, NO_RESULT}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_kind = '0;
  logic [15:0]        in_range_mm = '0;
  logic               in_last_sample = 1'b0;
  logic signed [15:0] in_speed = '0;
  logic signed [15:0] in_steering = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_result_kind;
  logic signed [15:0] out_speed;
  logic signed [15:0] out_steering;
  logic               out_braked;
  logic               out_front_led;
  logic               out_back_led;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  // Shadow of the monitor's registers and scan state
  cfg_t        cfg_m;
  logic        moving_q = 1'b0;
  logic        scan_fresh = 1'b1;
  logic [31:0] run_angle = '0;
  logic        front_seen = 1'b0;
  logic        back_seen = 1'b0;
  logic        block_fwd = 1'b0;
  logic        block_rev = 1'b0;

  res_t        pending_results [$];
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic        idle_on = 1'b1;
  int unsigned stall_left = 0;

  scan_sector_proximity_brake u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && rst_n && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic bit field_monitor_step(input item_t w, output res_t r);
    int  a;
    int  fh;
    int  bh;
    logic blocked;
    r = '0;
    fh = int'(cfg_m.front_half_width);
    bh = int'(cfg_m.back_half_width);
    case (w.kind)
      KIND_SCAN: begin
        if (scan_fresh) run_angle = {{16{cfg_m.angle_start[15]}}, cfg_m.angle_start};
        a = run_angle;
        if ((a < fh || a > TWO_PI_Q - fh) && w.range_mm <= cfg_m.front_margin)
          front_seen = 1'b1;
        if (a >= PI_Q - bh && a <= PI_Q + bh && w.range_mm <= cfg_m.back_margin)
          back_seen = 1'b1;
        run_angle = run_angle + {{16{cfg_m.angle_step[15]}}, cfg_m.angle_step};
        if (!w.last_sample) begin
          scan_fresh = 1'b0;
          return 1'b0;
        end
        // latch the scan's hits, but only while the vehicle moves
        block_fwd = front_seen && moving_q;
        block_rev = back_seen && moving_q;
        front_seen = 1'b0;
        back_seen = 1'b0;
        scan_fresh = 1'b1;
        r.result_kind = RK_LED;
        r.front_led = block_fwd;
        r.back_led = block_rev;
        return 1'b1;
      end
      KIND_ODO: begin
        moving_q = (w.speed != 0);
        return 1'b0;
      end
      KIND_DRIVE: begin
        blocked = (block_fwd && w.speed > 0) || (block_rev && w.speed < 0);
        r.result_kind = RK_DRIVE;
        r.out_speed = blocked ? 16'sd0 : w.speed;
        r.out_steering = w.steering;
        r.braked = blocked;
        r.front_led = block_fwd;
        r.back_led = block_rev;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic check_field(input string nm, input int want, input int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, nm, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result word with no expectation, expected none, actual kind %0d",
                 $time, out_result_kind);
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", want.result_kind, out_result_kind);
        check_field("out_speed", want.out_speed, out_speed);
        check_field("out_steering", want.out_steering, out_steering);
        check_field("braked", want.braked, out_braked);
        check_field("front_led", want.front_led, out_front_led);
        check_field("back_led", want.back_led, out_back_led);
      end
    end
  end

  task automatic feed_word(input item_t w, input logic typed, input res_t given);
    res_t        r;
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind <= w.kind;
    in_range_mm <= w.range_mm;
    in_last_sample <= w.last_sample;
    in_speed <= w.speed;
    in_steering <= w.steering;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (field_monitor_step(w, r)) pending_results.push_back(typed ? given : r);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // an odometry word may still be in flight with nothing expected
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_regs();
    logic [31:0] rd;
    logic [31:0] want;
    logic [31:0] mask;
    for (int r = REG_ANGLE_START; r <= REG_BACK_MARG; r++) begin
      apb_xfer(1'b0, 3'(r), $urandom, rd);
      mask = 32'hFFFF;
      case (3'(r))
        REG_ANGLE_START: want = {16'd0, cfg_m.angle_start};
        REG_ANGLE_STEP:  want = {16'd0, cfg_m.angle_step};
        REG_FRONT_HALF: begin
          want = {18'd0, cfg_m.front_half_width};
          mask = 32'h3FFF;
        end
        REG_BACK_HALF: begin
          want = {18'd0, cfg_m.back_half_width};
          mask = 32'h3FFF;
        end
        REG_FRONT_MARG:  want = {16'd0, cfg_m.front_margin};
        default:         want = {16'd0, cfg_m.back_margin};
      endcase
      if ((rd & mask) != want) begin
        mismatch_count++;
        $display("%0t ns: register %0d readback mismatch, expected %0h, actual %0h",
                 $time, r, want, rd & mask);
      end
    end
  endtask

  task automatic load_setup(input cfg_t c);
    logic [31:0] wr_data;
    logic [31:0] rd;
    for (int r = REG_ANGLE_START; r <= REG_SPARE_HI; r++) begin
      // upper bits carry junk; the registers keep only their own width
      wr_data = $urandom;
      case (3'(r))
        REG_ANGLE_START: begin
          wr_data[15:0] = c.angle_start;
          cfg_m.angle_start = c.angle_start;
        end
        REG_ANGLE_STEP: begin
          wr_data[15:0] = c.angle_step;
          cfg_m.angle_step = c.angle_step;
        end
        REG_FRONT_HALF: begin
          wr_data[13:0] = c.front_half_width;
          cfg_m.front_half_width = c.front_half_width;
        end
        REG_BACK_HALF: begin
          wr_data[13:0] = c.back_half_width;
          cfg_m.back_half_width = c.back_half_width;
        end
        REG_FRONT_MARG: begin
          wr_data[15:0] = c.front_margin;
          cfg_m.front_margin = c.front_margin;
        end
        REG_BACK_MARG: begin
          wr_data[15:0] = c.back_margin;
          cfg_m.back_margin = c.back_margin;
        end
        default: ;
      endcase
      apb_xfer(1'b1, 3'(r), wr_data, rd);
    end
    check_regs();
  endtask

  function automatic cfg_t rand_setup();
    cfg_t c;
    c.angle_start = 16'($urandom);
    c.angle_step = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 4000) - 2000);
    c.front_half_width = 14'($urandom_range(0, PI_Q));
    c.back_half_width = 14'($urandom_range(0, PI_Q));
    c.front_margin = 16'($urandom);
    c.back_margin = 16'($urandom);
    return c;
  endfunction

  function automatic item_t rand_word(input logic [1:0] k);
    item_t       w;
    int unsigned top;
    w.kind = k;
    w.range_mm = 16'($urandom);
    w.last_sample = 1'($urandom);
    w.speed = 16'($urandom);
    w.steering = 16'($urandom);
    top = (cfg_m.front_margin > cfg_m.back_margin) ? 32'(cfg_m.front_margin)
                                                   : 32'(cfg_m.back_margin);
    // keep half the ranges near the margins so hits and misses both show up
    if (k == KIND_SCAN && $urandom_range(0, 1) == 1)
      w.range_mm = 16'($urandom_range(0, (top < 65535) ? top + 1 : top));
    if (k != KIND_SCAN && $urandom_range(0, 3) == 0) w.speed = '0;
    return w;
  endfunction

  task automatic run_traffic(input int n_words, input logic pause_mid);
    item_t       w;
    int          sent;
    int unsigned len;
    int unsigned pick;
    logic        paused;
    sent = 0;
    paused = 1'b0;
    while (sent < n_words) begin
      if (pause_mid && !paused && sent >= n_words / 2) begin
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          w = rand_word(KIND_SCAN);
          w.last_sample = (i == len - 1);
          feed_word(w, 1'b0, NO_RESULT);
        end
        sent += len;
      end else if (pick < 70) begin
        feed_word(rand_word(KIND_ODO), 1'b0, NO_RESULT);
        sent++;
      end else if (pick < 93) begin
        feed_word(rand_word(KIND_DRIVE), 1'b0, NO_RESULT);
        sent++;
      end else if (pick < 97) begin
        feed_word(rand_word(KIND_UNUSED), 1'b0, NO_RESULT);
      end else begin
        // broken scan: samples that never see their last word here
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          w = rand_word(KIND_SCAN);
          w.last_sample = 1'b0;
          feed_word(w, 1'b0, NO_RESULT);
        end
        sent += len;
      end
    end
  endtask

  initial begin
    cfg_t  setup;
    cfg_m = '0;
    cfg_m.angle_step = 16'sd26;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    check_regs();

    setup = '0;
    setup.angle_step = 16'sd6434;
    setup.front_half_width = 14'd1000;
    setup.back_half_width = 14'd1000;
    setup.front_margin = 16'd500;
    setup.back_margin = 16'd500;
    load_setup(setup);
    foreach (DIR_TAB[i]) feed_word(DIR_TAB[i].w, DIR_TAB[i].typed, DIR_TAB[i].want);
    drain_results();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 0) begin
        setup = '0;
        setup.angle_start = 16'h8000;
        setup.angle_step = 16'h8000;
      end else if (ph == 1) begin
        setup.angle_start = 16'h7FFF;
        setup.angle_step = 16'h7FFF;
        setup.front_half_width = PI_Q;
        setup.back_half_width = PI_Q;
        setup.front_margin = '1;
        setup.back_margin = '1;
      end else begin
        setup = rand_setup();
      end
      idle_on = (ph != 6);
      load_setup(setup);
      run_traffic(PHASE_WORDS, ph == 3);
      drain_results();
    end

    if (mismatch_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
